// ----- src/fvne_pkg.sv -----
package fvne_pkg;

    // Map and fractal configuration.
    localparam int MAP_WIDTH    = 128;
    localparam int MAP_HEIGHT   = 112;
    localparam int OCTAVE_COUNT = 5;
    localparam int EDGE_MARGIN  = 16;

    // Pipeline depth of one octave cell.
    localparam int CELL_STAGES = 8;

    // Hash constants.
    localparam logic [31:0] MIX_K1     = 32'h7feb352d;
    localparam logic [31:0] MIX_K2     = 32'h846ca68b;
    localparam logic [31:0] LAT_KX     = 32'd374761393;
    localparam logic [31:0] LAT_KY     = 32'd668265263;
    localparam logic [31:0] OCT_STEP   = 32'd7919;
    localparam logic [31:0] SHAPE_SALT = 32'h2f6a88b3;

    // Sum of amplitudes 128, 64, ... over all octaves, and an exact reciprocal
    // for the 16-bit accumulator (error stays below one part in 256).
    localparam int NORM       = 256 - (256 >> OCTAVE_COUNT);
    localparam int NORM_SHIFT = 24;
    localparam int NORM_RECIP = ((1 << NORM_SHIFT) + NORM - 1) / NORM;

    // Period reciprocals are ceil(2^22 / p), exact for dividends below 2^15.
    localparam int RECIP_SHIFT = 22;

    // Width of border distance arithmetic.
    localparam int DIST_W = 12;

    // Settling counter load value; in_ready stays low until it reaches zero.
    localparam logic [2:0] SETTLE_CYCLES = 3'd4;

    typedef struct packed {
        logic [6:0]  x;
        logic [6:0]  y;
        logic [15:0] acc;
    } fvne_word_t;

    typedef struct packed {
        logic [6:0]  period;
        logic [21:0] recip;
        logic [31:0] seed;
        logic [2:0]  amp_shift;
    } fvne_cell_cfg_t;

    function automatic logic [7:0] shape_sea(input logic [1:0] shape);
        logic [7:0] r;
        case (shape)
            2'd0:    r = 8'd142;
            2'd1:    r = 8'd132;
            2'd2:    r = 8'd121;
            default: r = 8'd110;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] shape_period(input logic [1:0] shape);
        logic [6:0] r;
        case (shape)
            2'd0:    r = 7'd26;
            2'd1:    r = 7'd38;
            2'd2:    r = 7'd52;
            default: r = 7'd72;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] shape_sharp(input logic [1:0] shape);
        logic [1:0] r;
        case (shape)
            2'd0:    r = 2'd3;
            default: r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] shape_edge(input logic [1:0] shape);
        logic [6:0] r;
        case (shape)
            2'd0:    r = 7'd90;
            2'd1:    r = 7'd80;
            2'd2:    r = 7'd70;
            default: r = 7'd55;
        endcase
        return r;
    endfunction

    // Base period halved per octave, never below 2.
    function automatic logic [6:0] octave_period(input logic [1:0] shape,
                                                 input logic [2:0] oct);
        logic [6:0] p;
        p = shape_period(shape) >> oct;
        return (p < 7'd2) ? 7'd2 : p;
    endfunction

    function automatic logic [21:0] period_recip(input logic [6:0] p);
        logic [21:0] r;
        case (p)
            7'd2:    r = 22'd2097152;
            7'd3:    r = 22'd1398102;
            7'd4:    r = 22'd1048576;
            7'd6:    r = 22'd699051;
            7'd9:    r = 22'd466034;
            7'd13:   r = 22'd322639;
            7'd18:   r = 22'd233017;
            7'd19:   r = 22'd220753;
            7'd26:   r = 22'd161320;
            7'd36:   r = 22'd116509;
            7'd38:   r = 22'd110377;
            7'd52:   r = 22'd80660;
            7'd72:   r = 22'd58255;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/fractal_value_noise_elevation_top.sv -----
// Channel  Direction  Handshake              Payload
// input    in         in_valid / in_ready    cell_x[6:0], cell_y[6:0]
// output   out        out_valid / out_ready  elevation[7:0]
// config   in         seed_we                world_seed[31:0]
//
// One word enters per cycle and one elevation leaves per cycle unless stalled;
// a word passes the OCTAVE_COUNT octave cells, then 3 post stages.
// The whole pipeline advances only when the output register is empty or taken,
// so a stall on out_ready holds every stage and drops in_ready.
// After reset and after each seed write, in_ready stays low while the world
// shape and the per-octave settings are derived from the seed.
module fractal_value_noise_elevation_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [6:0]  cell_x,
    input  logic [6:0]  cell_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  elevation,
    input  logic        seed_we,
    input  logic [31:0] world_seed
);
    import fvne_pkg::*;

    // Seed register and derived settings.
    logic [31:0] seed_reg;
    logic [31:0] eff_seed;
    logic [31:0] shp_in;
    logic [31:0] c1_reg, c2_reg;
    logic [1:0]  shape_reg;
    logic [2:0]  busy_reg, busy_next;
    logic [7:0]  sea_reg;
    logic [1:0]  sharp_reg;
    logic [6:0]  edge_reg;
    fvne_cell_cfg_t cell_cfg_reg [OCTAVE_COUNT];

    // Pipeline control.
    logic adv;
    logic in_fire;

    // Chain of octave cells.
    logic       chain_vld  [OCTAVE_COUNT+1];
    fvne_word_t chain_word [OCTAVE_COUNT+1];

    // Post-processing stages.
    logic        p1_vld_reg, p2_vld_reg, out_vld_reg;
    logic [32:0] norm_prod;
    logic [7:0]  h1_reg;
    logic [6:0]  x1_reg, y1_reg;
    logic signed [DIST_W-1:0] dx, dy, dmin, tdist;
    logic [2*DIST_W-1:0] tt_full;
    logic [2*DIST_W-1:0] tt2_reg;
    logic signed [9:0]  hd;
    logic signed [10:0] h2_full;
    logic signed [10:0] h2_reg;
    logic [30:0] fall_prod;
    logic signed [24:0] final_diff;
    logic [7:0]  elev_reg;
    logic [7:0]  elev_next;

    assign eff_seed = (seed_reg == 32'd0) ? 32'd1 : seed_reg;
    assign shp_in   = eff_seed ^ SHAPE_SALT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 32'd1;
            busy_reg <= SETTLE_CYCLES;
        end
        else
        begin
            if (seed_we)
            begin
                seed_reg <= world_seed;
            end
            busy_reg <= busy_next;
        end
    end

    always_comb
    begin
        if (seed_we)
        begin
            busy_next = SETTLE_CYCLES;
        end
        else if (busy_reg != 3'd0)
        begin
            busy_next = busy_reg - 3'd1;
        end
        else
        begin
            busy_next = busy_reg;
        end
    end

    // The shape is the low two bits of the mixed, salted seed XOR its bits 17:16.
    always_ff @(posedge clk)
    begin
        c1_reg    <= 32'((shp_in ^ (shp_in >> 16)) * MIX_K1);
        c2_reg    <= 32'((c1_reg ^ (c1_reg >> 15)) * MIX_K2);
        shape_reg <= c2_reg[1:0] ^ c2_reg[17:16];
        sea_reg   <= shape_sea(shape_reg);
        sharp_reg <= shape_sharp(shape_reg);
        edge_reg  <= shape_edge(shape_reg);
        for (int i = 0; i < OCTAVE_COUNT; i++)
        begin
            cell_cfg_reg[i].period    <= octave_period(shape_reg, 3'(i));
            cell_cfg_reg[i].recip     <= period_recip(octave_period(shape_reg, 3'(i)));
            cell_cfg_reg[i].seed      <= eff_seed + 32'(32'(i) * OCT_STEP);
            cell_cfg_reg[i].amp_shift <= 3'(7 - i);
        end
    end

    assign adv      = !out_vld_reg || out_ready;
    assign in_ready = adv && (busy_reg == 3'd0);
    assign in_fire  = in_valid && in_ready;

    assign chain_vld[0]      = in_fire;
    assign chain_word[0].x   = cell_x;
    assign chain_word[0].y   = cell_y;
    assign chain_word[0].acc = 16'd0;

    for (genvar g = 0; g < OCTAVE_COUNT; g++)
    begin : g_oct
        fvne_octave_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (chain_vld[g]),
            .in_word   (chain_word[g]),
            .cfg       (cell_cfg_reg[g]),
            .out_valid (chain_vld[g+1]),
            .out_word  (chain_word[g+1])
        );
    end

    // Post stage 1: normalize the sum and find the border distance.
    assign norm_prod = 33'(chain_word[OCTAVE_COUNT].acc) * 33'(NORM_RECIP);
    assign dx   = ($signed(DIST_W'(chain_word[OCTAVE_COUNT].x))
                   < $signed(DIST_W'(MAP_WIDTH - 1)) - $signed(DIST_W'(chain_word[OCTAVE_COUNT].x)))
                  ? $signed(DIST_W'(chain_word[OCTAVE_COUNT].x))
                  : $signed(DIST_W'(MAP_WIDTH - 1)) - $signed(DIST_W'(chain_word[OCTAVE_COUNT].x));
    assign dy   = ($signed(DIST_W'(chain_word[OCTAVE_COUNT].y))
                   < $signed(DIST_W'(MAP_HEIGHT - 1)) - $signed(DIST_W'(chain_word[OCTAVE_COUNT].y)))
                  ? $signed(DIST_W'(chain_word[OCTAVE_COUNT].y))
                  : $signed(DIST_W'(MAP_HEIGHT - 1)) - $signed(DIST_W'(chain_word[OCTAVE_COUNT].y));
    assign dmin  = (dx < dy) ? dx : dy;
    assign tdist = $signed(DIST_W'(EDGE_MARGIN)) - dmin;
    assign tt_full = (dmin < $signed(DIST_W'(EDGE_MARGIN)))
                     ? (2*DIST_W)'(tdist * tdist) : '0;

    // Post stage 2: sharpen around sea level (floor shift); carry the falloff term.
    assign hd      = $signed({2'b0, h1_reg}) - $signed({2'b0, sea_reg});
    assign h2_full = $signed({3'b0, h1_reg}) + 11'(hd >>> sharp_reg);

    // Post stage 3: falloff (margin squared is 256) and saturation.
    assign fall_prod  = 31'(tt2_reg) * 31'(edge_reg);
    assign final_diff = 25'(h2_reg) - $signed({2'b0, fall_prod[30:8]});

    always_comb
    begin
        if (final_diff < 0)
        begin
            elev_next = 8'd0;
        end
        else if (final_diff > 25'sd255)
        begin
            elev_next = 8'd255;
        end
        else
        begin
            elev_next = final_diff[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_vld_reg  <= chain_vld[OCTAVE_COUNT];
            p2_vld_reg  <= p1_vld_reg;
            out_vld_reg <= p2_vld_reg;
        end
    end

    // x1_reg and y1_reg keep the coordinate alongside the first post stage.
    logic [2*DIST_W-1:0] tt1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h1_reg   <= norm_prod[31:24];
            x1_reg   <= chain_word[OCTAVE_COUNT].x;
            y1_reg   <= chain_word[OCTAVE_COUNT].y;
            tt1_reg  <= tt_full;
            h2_reg   <= h2_full;
            tt2_reg  <= tt1_reg;
            elev_reg <= elev_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign elevation = elev_reg;

    // A seed write always holds off new words while settings settle.
    assert property (@(posedge clk) disable iff (!rst_n) seed_we |=> !in_ready)
        else $error("word accepted right after a seed write");

    // No word enters while the derived settings are still settling.
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg != 3'd0) |-> !in_fire)
        else $error("word accepted while settling");

    // Once settled, the shape holds until the next seed write.
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg == 3'd0) && !seed_we && $past(busy_reg == 3'd0) |=> $stable(shape_reg))
        else $error("shape changed without a seed write");

    // The coordinate carried into post stage 1 stays with its word.
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && chain_vld[OCTAVE_COUNT] |=> (x1_reg == $past(chain_word[OCTAVE_COUNT].x))
                                          && (y1_reg == $past(chain_word[OCTAVE_COUNT].y)))
        else $error("post stage lost its coordinate");

endmodule

// ----- src/fvne_octave_cell.sv -----
// One octave of value noise. The word moves through eight stages; the last
// stage adds the weighted octave value to the running sum.
module fvne_octave_cell
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  fvne_pkg::fvne_word_t    in_word,
    input  fvne_pkg::fvne_cell_cfg_t cfg,
    output logic                    out_valid,
    output fvne_pkg::fvne_word_t    out_word
);
    import fvne_pkg::*;

    logic [CELL_STAGES-1:0] vld_reg;
    logic [CELL_STAGES-1:0] vld_next;
    fvne_word_t             word_reg [CELL_STAGES];

    // Stage 1: lattice index.
    logic [28:0] qx_prod, qy_prod;
    logic [6:0]  qx1_reg, qy1_reg;
    // Stage 2: remainder and hash halves.
    logic [13:0] rxp, ryp;
    logic [6:0]  rx2_reg, ry2_reg;
    logic [31:0] ha2_reg, hb2_reg;
    // Stage 3: fraction and corner hash inputs.
    logic [36:0] fx_prod, fy_prod;
    logic [7:0]  f3_reg [2];
    logic [31:0] h3_reg [4];
    // Stage 4 and 5: mixing and smoothstep.
    logic [31:0] m4_reg [4];
    logic [31:0] m5_reg [4];
    logic [15:0] sq [2];
    logic [15:0] cu [2];
    logic [7:0]  f4_reg [2];
    logic [7:0]  t2_4_reg [2];
    logic [7:0]  t2_5_reg [2];
    logic [7:0]  t3_5_reg [2];
    // Stage 6: lattice values and weights.
    logic [7:0]  lat6_reg [4];
    logic [8:0]  s6_reg [2];
    logic [9:0]  s_full [2];
    // Stage 7: top and bottom rows.
    logic signed [8:0]  dtop, dbot, dmid;
    logic signed [18:0] ptop, pbot, pmid;
    logic [7:0]  top7_reg, bot7_reg;
    logic [8:0]  sy7_reg;
    logic [10:0] top_sum, bot_sum, mid_sum;
    logic [7:0]  oct_val;

    assign vld_next = {vld_reg[CELL_STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    assign qx_prod = 29'(in_word.x) * 29'(cfg.recip);
    assign qy_prod = 29'(in_word.y) * 29'(cfg.recip);
    assign rxp     = 14'(qx1_reg) * 14'(cfg.period);
    assign ryp     = 14'(qy1_reg) * 14'(cfg.period);
    assign fx_prod = 37'({rx2_reg, 8'b0}) * 37'(cfg.recip);
    assign fy_prod = 37'({ry2_reg, 8'b0}) * 37'(cfg.recip);

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            sq[k]     = 16'(f3_reg[k]) * 16'(f3_reg[k]);
            cu[k]     = 16'(t2_4_reg[k]) * 16'(f4_reg[k]);
            s_full[k] = 10'(10'(t2_5_reg[k]) * 10'd3) - 10'({t3_5_reg[k], 1'b0});
        end
    end

    // Bilinear blend; each interpolation stays between its two end values.
    assign dtop    = $signed({1'b0, lat6_reg[1]}) - $signed({1'b0, lat6_reg[0]});
    assign dbot    = $signed({1'b0, lat6_reg[3]}) - $signed({1'b0, lat6_reg[2]});
    assign ptop    = 19'(dtop) * $signed({10'b0, s6_reg[0]});
    assign pbot    = 19'(dbot) * $signed({10'b0, s6_reg[0]});
    assign top_sum = 11'(lat6_reg[0]) + 11'(ptop >>> 8);
    assign bot_sum = 11'(lat6_reg[2]) + 11'(pbot >>> 8);
    assign dmid    = $signed({1'b0, bot7_reg}) - $signed({1'b0, top7_reg});
    assign pmid    = 19'(dmid) * $signed({10'b0, sy7_reg});
    assign mid_sum = 11'(top7_reg) + 11'(pmid >>> 8);
    assign oct_val = mid_sum[7:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            word_reg[0] <= in_word;
            for (int i = 1; i < CELL_STAGES - 1; i++)
            begin
                word_reg[i] <= word_reg[i-1];
            end
            word_reg[CELL_STAGES-1].x   <= word_reg[CELL_STAGES-2].x;
            word_reg[CELL_STAGES-1].y   <= word_reg[CELL_STAGES-2].y;
            word_reg[CELL_STAGES-1].acc <= word_reg[CELL_STAGES-2].acc
                                           + (16'(oct_val) << cfg.amp_shift);

            qx1_reg <= qx_prod[28:22];
            qy1_reg <= qy_prod[28:22];

            rx2_reg <= word_reg[0].x - rxp[6:0];
            ry2_reg <= word_reg[0].y - ryp[6:0];
            ha2_reg <= 32'(32'(qx1_reg) * LAT_KX);
            hb2_reg <= 32'(32'(qy1_reg) * LAT_KY) + cfg.seed;

            f3_reg[0] <= fx_prod[29:22];
            f3_reg[1] <= fy_prod[29:22];
            h3_reg[0] <= ha2_reg + hb2_reg;
            h3_reg[1] <= ha2_reg + hb2_reg + LAT_KX;
            h3_reg[2] <= ha2_reg + hb2_reg + LAT_KY;
            h3_reg[3] <= ha2_reg + hb2_reg + (LAT_KX + LAT_KY);

            for (int k = 0; k < 4; k++)
            begin
                m4_reg[k]   <= 32'((h3_reg[k] ^ (h3_reg[k] >> 16)) * MIX_K1);
                m5_reg[k]   <= 32'((m4_reg[k] ^ (m4_reg[k] >> 15)) * MIX_K2);
                // The final fold leaves the top byte untouched.
                lat6_reg[k] <= m5_reg[k][31:24];
            end

            for (int k = 0; k < 2; k++)
            begin
                f4_reg[k]   <= f3_reg[k];
                t2_4_reg[k] <= sq[k][15:8];
                t2_5_reg[k] <= t2_4_reg[k];
                t3_5_reg[k] <= cu[k][15:8];
                s6_reg[k]   <= s_full[k][8:0];
            end

            top7_reg <= top_sum[7:0];
            bot7_reg <= bot_sum[7:0];
            sy7_reg  <= s6_reg[1];
        end
    end

    assign out_valid = vld_reg[CELL_STAGES-1];
    assign out_word  = word_reg[CELL_STAGES-1];

endmodule
